// ===== rtl/core/grp_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// grp_pkg
// Shared types and constants of the grid ray march caster.
// ---------------------------------------------------------------------------
package grp_pkg;

    localparam int MAP_COLS_DEF  = 8;
    localparam int MAP_ROWS_DEF  = 8;
    localparam int MAX_STEPS_DEF = 200;
    localparam int RAY_COUNT_DEF = 120;

    localparam int TILE_Q16 = 50 * 65536;

    localparam int SIN_A = 102944;
    localparam int SIN_B = 42048;
    localparam int SIN_C = 4640;

    localparam logic [63:0] MAP_RESET = 64'd1097390195199;
    localparam logic [14:0] FOV_RESET = 15'd10430;

    localparam int DS_SRC_W = 56;
    localparam int DS_Q_W   = 28;
    localparam int DS_REM_W = 30;
    localparam int DS_DIV_STEPS  = 20;
    localparam int DS_SQRT_STEPS = 28;

    localparam logic [3:0] ADDR_MAP = 4'd0;
    localparam logic [3:0] ADDR_FOV = 4'd8;

    localparam logic [19:0] HEIGHT_NUM = 20'd640000;

    typedef struct packed {
        logic start;
        logic sqrt_mode;
    } t_ds_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_ds_rsp;

endpackage
`default_nettype wire

// ===== rtl/core/grp_mul.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// grp_mul
// Shared unsigned 32x32 multiplier, product registered.
// ---------------------------------------------------------------------------
module grp_mul (
    input  wire logic        i_clk,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    output logic      [63:0] o_p
);

    logic [63:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule
`default_nettype wire

// ===== rtl/core/grp_divsqrt.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// grp_divsqrt
// Iterative restoring divider and integer square root sharing one
// compare-subtract; one quotient or root bit per cycle.
// ---------------------------------------------------------------------------
module grp_divsqrt (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire grp_pkg::t_ds_req               i_req,
    input  wire logic [grp_pkg::DS_SRC_W-1:0]   i_src,
    input  wire logic [15:0]                    i_dvs,
    output grp_pkg::t_ds_rsp                    o_rsp,
    output logic      [grp_pkg::DS_Q_W-1:0]     o_q
);

    localparam int RW = grp_pkg::DS_REM_W;
    localparam int QW = grp_pkg::DS_Q_W;
    localparam int SW = grp_pkg::DS_SRC_W;

    logic [SW-1:0] r_src;
    logic [RW-1:0] r_rem;
    logic [QW-1:0] r_q;
    logic [4:0]    r_cnt;
    logic          r_busy;
    logic          r_done;
    logic          r_sqrt;
    logic [15:0]   r_dvs;

    logic [RW:0] rem_sh;
    logic [RW:0] trial;
    logic        ge;
    logic [RW:0] diff;

    always_comb begin
        if (r_sqrt) begin
            rem_sh = {r_rem[RW-2:0], r_src[SW-1 -: 2]};
            trial  = (RW+1)'({r_q, 2'b01});
        end else begin
            rem_sh = {r_rem, r_src[SW-1]};
            trial  = (RW+1)'(r_dvs);
        end
        ge   = rem_sh >= trial;
        diff = rem_sh - trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 5'd1) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_src  <= i_src;
            r_rem  <= '0;
            r_q    <= '0;
            r_sqrt <= i_req.sqrt_mode;
            r_dvs  <= i_dvs;
            r_cnt  <= i_req.sqrt_mode ? 5'(grp_pkg::DS_SQRT_STEPS)
                                      : 5'(grp_pkg::DS_DIV_STEPS);
        end else if (r_busy) begin
            r_rem <= ge ? diff[RW-1:0] : rem_sh[RW-1:0];
            r_q   <= {r_q[QW-2:0], ge};
            r_src <= r_sqrt ? {r_src[SW-3:0], 2'b00} : {r_src[SW-2:0], 1'b0};
            r_cnt <= r_cnt - 5'd1;
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_q        = r_q;

endmodule
`default_nettype wire

// ===== rtl/core/grid_ray_march_caster.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// grid_ray_march_caster
// Fixed-step ray marcher over a bitmap tile map.
// ---------------------------------------------------------------------------
// One ray request is taken while the block is idle and gives one result beat.
// After acceptance a request runs through the column span (a reciprocal
// multiply), the three sines on the shared multiplier, the march (at most
// MAX_STEPS steps, one step per cycle), the squared length, the square root,
// the cosine scaling, the wall height divide (skipped when the distance is
// zero or negative) and the output stage. The block is ready again in the
// cycle after the output stage, so it takes no new ray while one is in
// flight. A result still waiting on the output holds the next ray in its
// output stage.
// No clearing pass follows reset.
module grid_ray_march_caster #(
    parameter int MAP_COLS  = grp_pkg::MAP_COLS_DEF,
    parameter int MAP_ROWS  = grp_pkg::MAP_ROWS_DEF,
    parameter int MAX_STEPS = grp_pkg::MAX_STEPS_DEF,
    parameter int RAY_COUNT = grp_pkg::RAY_COUNT_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [15:0]        i_pos_x,
    input  wire logic [15:0]        i_pos_y,
    input  wire logic [15:0]        i_view_angle,
    input  wire logic [6:0]         i_ray_index,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [17:0]      o_hit_x,
    output logic signed [17:0]      o_hit_y,
    output logic                    o_wall_hit,
    output logic signed [16:0]      o_distance,
    output logic        [15:0]      o_wall_height,
    output logic        [7:0]       o_brightness,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [63:0]        pwdata,
    output logic      [63:0]        prdata,
    output logic                    pready
);

    localparam int STW = $clog2(MAX_STEPS + 1);
    localparam logic signed [29:0] X_LIM = 30'(MAP_COLS * grp_pkg::TILE_Q16);
    localparam logic signed [29:0] Y_LIM = 30'(MAP_ROWS * grp_pkg::TILE_Q16);
    // ceil(2^32 / RAY_COUNT), exact for products below 2^22
    localparam logic [31:0] SPAN_RCP = (RAY_COUNT == 1) ? 32'd1 :
        32'(((64'd1 << 32) + 64'(RAY_COUNT) - 64'd1) / 64'(RAY_COUNT));

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_SPAN  = 14'b00000000000010,
        S_RCP   = 14'b00000000000100,
        S_OFFS  = 14'b00000000001000,
        S_TRIG  = 14'b00000000010000,
        S_MARCH = 14'b00000000100000,
        S_SQ0   = 14'b00000001000000,
        S_SQ1   = 14'b00000010000000,
        S_SQ2   = 14'b00000100000000,
        S_SQRT  = 14'b00001000000000,
        S_SCL0  = 14'b00010000000000,
        S_SCL1  = 14'b00100000000000,
        S_HDIV  = 14'b01000000000000,
        S_OUT   = 14'b10000000000000
    } t_state;

    t_state r_state;

    logic [63:0] r_map;
    logic [14:0] r_fov;

    logic [15:0]        r_px, r_py, r_view, r_offset, r_ray;
    logic [6:0]         r_idx;
    logic signed [17:0] r_cx, r_sy, r_cos;
    logic signed [29:0] r_x, r_y;
    logic [STW-1:0]     r_step;
    logic               r_hit;
    logic [2:0]         r_k;
    logic [1:0]         r_sel;
    logic [14:0]        r_z, r_z2;
    logic               r_neg;
    logic [54:0]        r_sq;
    logic signed [16:0] r_dist;
    logic [15:0]        r_height;
    logic               r_out_valid;

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;

    grp_pkg::t_ds_req ds_req;
    grp_pkg::t_ds_rsp ds_rsp;
    logic [grp_pkg::DS_SRC_W-1:0] ds_src;
    logic [15:0] ds_dvs;
    logic [grp_pkg::DS_Q_W-1:0] ds_q;

    grp_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    grp_divsqrt u_ds (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ds_req),
        .i_src   (ds_src),
        .i_dvs   (ds_dvs),
        .o_rsp   (ds_rsp),
        .o_q     (ds_q)
    );

    // configuration
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map <= grp_pkg::MAP_RESET;
            r_fov <= grp_pkg::FOV_RESET;
        end else if (cfg_wr) begin
            if (paddr == grp_pkg::ADDR_MAP) begin
                r_map <= pwdata;
            end else if (paddr == grp_pkg::ADDR_FOV) begin
                r_fov <= pwdata[14:0];
            end
        end
    end

    always_comb begin
        if (paddr == grp_pkg::ADDR_MAP) begin
            prdata = r_map;
        end else if (paddr == grp_pkg::ADDR_FOV) begin
            prdata = {49'd0, r_fov};
        end else begin
            prdata = '0;
        end
    end

    // sine argument
    logic [15:0] ang;
    logic [14:0] z;
    always_comb begin
        case (r_sel)
            2'd0:    ang = r_ray + 16'd16384;
            2'd1:    ang = r_ray;
            default: ang = r_offset + 16'd16384;
        endcase
        z = ang[14] ? 15'd16384 - {1'b0, ang[13:0]} : {1'b0, ang[13:0]};
    end

    logic [16:0] p14;
    logic [16:0] t_b, t_a;
    logic signed [17:0] sin_res;
    assign p14     = mul_p[30:14];
    assign t_b     = 17'(grp_pkg::SIN_B) - p14;
    assign t_a     = 17'(grp_pkg::SIN_A) - p14;
    assign sin_res = r_neg ? -$signed({1'b0, p14}) : $signed({1'b0, p14});

    // wall lookup on the current position
    logic [2:0] col, row;
    logic       wall;
    always_comb begin
        col = '0;
        row = '0;
        for (int k = 1; k < MAP_COLS; k++) begin
            if (r_x >= $signed(30'(k * grp_pkg::TILE_Q16))) begin
                col = col + 3'd1;
            end
        end
        for (int k = 1; k < MAP_ROWS; k++) begin
            if (r_y >= $signed(30'(k * grp_pkg::TILE_Q16))) begin
                row = row + 3'd1;
            end
        end
        wall = !r_x[29] && !r_y[29] && (r_x < X_LIM) && (r_y < Y_LIM)
               && r_map[{row, col}];
    end

    // displacement
    logic signed [29:0] x0, y0, dx, dy;
    logic [28:0] adx, ady;
    assign x0  = $signed({4'd0, r_px, 10'd0});
    assign y0  = $signed({4'd0, r_py, 10'd0});
    assign dx  = r_x - x0;
    assign dy  = r_y - y0;
    assign adx = dx[29] ? 29'(-dx) : dx[28:0];
    assign ady = dy[29] ? 29'(-dy) : dy[28:0];

    logic [16:0] acos;
    assign acos = r_cos[17] ? 17'(-r_cos) : r_cos[16:0];

    logic [18:0] mag_raw;
    logic [15:0] mag;
    logic signed [16:0] dist_n;
    assign mag_raw = mul_p[44:26];
    assign mag     = (mag_raw > 19'd65535) ? 16'hFFFF : mag_raw[15:0];
    assign dist_n  = r_cos[17] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

    logic [15:0] span_q;
    logic [15:0] span_off;
    assign span_q   = (RAY_COUNT == 1) ? mul_p[15:0] : mul_p[47:32];
    assign span_off = span_q - {2'b0, r_fov[14:1]};

    logic out_free;
    assign out_free = !r_out_valid || i_out_ready;

    // shared unit operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        ds_req.start     = 1'b0;
        ds_req.sqrt_mode = 1'b0;
        ds_src = '0;
        ds_dvs = '0;
        case (r_state)
            S_SPAN: begin
                mul_a = {25'd0, r_idx};
                mul_b = {17'd0, r_fov};
            end
            S_RCP: begin
                mul_a = mul_p[31:0];
                mul_b = SPAN_RCP;
            end
            S_TRIG: begin
                case (r_k)
                    3'd0: begin
                        mul_a = {17'd0, z};
                        mul_b = {17'd0, z};
                    end
                    3'd1: begin
                        mul_a = 32'(grp_pkg::SIN_C);
                        mul_b = {17'd0, mul_p[28:14]};
                    end
                    3'd2: begin
                        mul_a = {15'd0, t_b};
                        mul_b = {17'd0, r_z2};
                    end
                    3'd3: begin
                        mul_a = {15'd0, t_a};
                        mul_b = {17'd0, r_z};
                    end
                    default: ;
                endcase
            end
            S_SQ0: begin
                mul_a = {3'd0, adx};
                mul_b = {3'd0, adx};
            end
            S_SQ1: begin
                mul_a = {3'd0, ady};
                mul_b = {3'd0, ady};
            end
            S_SQ2: begin
                ds_req.start     = 1'b1;
                ds_req.sqrt_mode = 1'b1;
                ds_src = {1'b0, r_sq + mul_p[54:0]};
            end
            S_SCL0: begin
                mul_a = {4'd0, ds_q};
                mul_b = {15'd0, acos};
            end
            S_SCL1: begin
                ds_req.start = !r_cos[17] && (mag != 16'd0);
                ds_src = {grp_pkg::HEIGHT_NUM, 36'd0};
                ds_dvs = mag;
            end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_SPAN;
                    end
                end
                S_SPAN:  r_state <= S_RCP;
                S_RCP:   r_state <= S_OFFS;
                S_OFFS:  r_state <= S_TRIG;
                S_TRIG: begin
                    if (r_k == 3'd4 && r_sel == 2'd2) begin
                        r_state <= S_MARCH;
                    end
                end
                S_MARCH: begin
                    if ((r_step != '0 && wall) || r_step == STW'(MAX_STEPS)) begin
                        r_state <= S_SQ0;
                    end
                end
                S_SQ0:   r_state <= S_SQ1;
                S_SQ1:   r_state <= S_SQ2;
                S_SQ2:   r_state <= S_SQRT;
                S_SQRT: begin
                    if (ds_rsp.done) begin
                        r_state <= S_SCL0;
                    end
                end
                S_SCL0:  r_state <= S_SCL1;
                S_SCL1:  r_state <= ds_req.start ? S_HDIV : S_OUT;
                S_HDIV: begin
                    if (ds_rsp.done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // datapath
    logic signed [18:0] bright_v;
    assign bright_v = 19'sd16320 - $signed({r_dist[16], r_dist, 1'b0});

    function automatic logic signed [17:0] to_q6(input logic signed [29:0] p);
        logic signed [29:0] s;
        logic signed [19:0] v;
        s = p >>> 10;
        v = s[19:0];
        if (v < -20'sd32768) begin
            return -18'sd32768;
        end else if (v > 20'sd98303) begin
            return 18'sd98303;
        end
        return v[17:0];
    endfunction

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_px   <= i_pos_x;
                r_py   <= i_pos_y;
                r_view <= i_view_angle;
                r_idx  <= i_ray_index;
                r_k    <= '0;
                r_sel  <= '0;
                r_step <= '0;
                r_hit  <= 1'b0;
            end
            S_OFFS: begin
                r_offset <= span_off;
                r_ray    <= r_view + span_off;
                r_x      <= x0;
                r_y      <= y0;
            end
            S_TRIG: begin
                case (r_k)
                    3'd0: begin
                        r_z   <= z;
                        r_neg <= ang[15];
                        r_k   <= 3'd1;
                    end
                    3'd1: begin
                        r_z2 <= mul_p[28:14];
                        r_k  <= 3'd2;
                    end
                    3'd4: begin
                        case (r_sel)
                            2'd0:    r_cx  <= sin_res;
                            2'd1:    r_sy  <= sin_res;
                            default: r_cos <= sin_res;
                        endcase
                        r_sel <= r_sel + 2'd1;
                        r_k   <= 3'd0;
                    end
                    default: r_k <= r_k + 3'd1;
                endcase
            end
            S_MARCH: begin
                if (r_step != '0 && wall) begin
                    r_hit <= 1'b1;
                end else if (r_step != STW'(MAX_STEPS)) begin
                    r_x    <= r_x + 30'(r_cx);
                    r_y    <= r_y + 30'(r_sy);
                    r_step <= r_step + STW'(1);
                end
            end
            S_SQ1: r_sq <= mul_p[54:0];
            S_SCL1: begin
                r_dist <= dist_n;
                if (mag == 16'd0) begin
                    r_height <= 16'hFFFF;
                end else begin
                    r_height <= 16'd0;
                end
            end
            S_HDIV: begin
                if (ds_rsp.done) begin
                    r_height <= (ds_q[19:0] > 20'd65535) ? 16'hFFFF : ds_q[15:0];
                end
            end
            S_OUT: begin
                if (out_free) begin
                    o_hit_x       <= to_q6(r_x);
                    o_hit_y       <= to_q6(r_y);
                    o_wall_hit    <= r_hit;
                    o_distance    <= r_dist;
                    o_wall_height <= r_height;
                    if (bright_v <= 19'sd0) begin
                        o_brightness <= 8'd0;
                    end else if (bright_v[17:6] > 12'd255) begin
                        o_brightness <= 8'd255;
                    end else begin
                        o_brightness <= bright_v[13:6];
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_SPAN))
        else $error("accepted beat did not start a ray");
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MARCH) |-> (r_step <= STW'(MAX_STEPS)))
        else $error("march step count past limit");
    a_ds_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ds_rsp.done |-> (r_state == S_SQRT || r_state == S_HDIV))
        else $error("divider finished outside a waiting state");
    a_ds_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ds_req.start |-> !ds_rsp.busy)
        else $error("divider started while busy");
`endif

endmodule
`default_nettype wire
